FILE: design/swsd_pkg.sv
`default_nettype none

package swsd_pkg;

  // Stack geometry.
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 30;

  // Request kinds.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_PEEK  = 2'd2;
  localparam logic [1:0] KIND_DRAIN = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap;         // capture the accepted request
    logic       push;        // write the value on top
    logic       pop;         // drop the top entry
    logic       rd_top;      // read the top entry
    logic       drain_init;  // clear the last emitted key and the drain cursor
    logic       scan_init;   // restart a minimum search
    logic       scan_rd;     // read the next entry of the search
    logic       emit_top;    // load the top entry into the result register
    logic       emit_sort;   // load the current minimum into the result register
    logic       emit_code;   // load a status-only result
    logic [1:0] code;        // status for emit_code
  } swsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       scan_last;
    logic       sort_last;
    logic       out_free;
  } swsd_sts_t;

endpackage

`default_nettype wire

FILE: design/swsd_if.sv
`default_nettype none

// Request channel: one stack operation.
interface swsd_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [swsd_pkg::VW-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// Result channel: one answer.
interface swsd_out_if;
  logic                    valid;
  logic                    ready;
  logic [swsd_pkg::VW-1:0] value_res;
  logic [1:0]              status;
  logic                    last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: design/stack_with_sorted_drain.sv
// Push and pop are carried out in S_EXEC; a peek reads the top entry in S_EXEC and loads it
// into the result register in S_PEEK. A drain of n entries runs n minimum searches over the
// stack memory, one read per cycle through the registered port.
// One request is worked at a time; the result register frees the request side once loaded.
// Reset (rst, synchronous, active high) empties the stack and clears the result valid flag.
`default_nettype none

module stack_with_sorted_drain (
  input wire logic clk,
  input wire logic rst,
  swsd_in_if.sink  item,
  swsd_out_if.source result
);

  swsd_pkg::swsd_cmd_t cmd;
  swsd_pkg::swsd_sts_t sts;

  // Sequencer.
  swsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, search and result register.
  swsd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (item.kind),
    .in_value   (item.value),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_value  (result.value_res),
    .out_status (result.status),
    .out_last   (result.last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

FILE: design/swsd_ctrl.sv
`default_nettype none

module swsd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire swsd_pkg::swsd_sts_t sts,
  output swsd_pkg::swsd_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_PEEK     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = swsd_pkg::ST_EMPTY;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.kind)
          swsd_pkg::KIND_PUSH: begin
            if (!sts.full) begin
              cmd.push   = 1'b1;
              state_next = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              cmd.code      = swsd_pkg::ST_OVER;
              state_next    = S_IDLE;
            end
          end
          swsd_pkg::KIND_POP: begin
            if (!sts.empty) begin
              cmd.pop    = 1'b1;
              state_next = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              state_next    = S_IDLE;
            end
          end
          swsd_pkg::KIND_PEEK: begin
            if (!sts.empty) begin
              cmd.rd_top = 1'b1;
              state_next = S_PEEK;
            end else if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              state_next    = S_IDLE;
            end
          end
          default: begin
            if (!sts.empty) begin
              cmd.drain_init = 1'b1;
              cmd.scan_init  = 1'b1;
              state_next     = S_SCAN;
            end else if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              state_next    = S_IDLE;
            end
          end
        endcase
      end
      S_PEEK: begin
        if (sts.out_free) begin
          cmd.emit_top = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_sort = 1'b1;
          if (sts.sort_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/swsd_dp.sv
`default_nettype none

module swsd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [swsd_pkg::VW-1:0]       in_value,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [swsd_pkg::VW-1:0]            out_value,
  output logic [1:0]                         out_status,
  output logic                               out_last,
  input  wire swsd_pkg::swsd_cmd_t           cmd,
  output swsd_pkg::swsd_sts_t                sts
);

  // Stack storage, read through a registered port.
  logic [swsd_pkg::VW-1:0] mem [swsd_pkg::DEPTH];
  logic [swsd_pkg::VW-1:0] rd_data;
  logic [swsd_pkg::AW-1:0] rd_addr;

  // Captured request.
  logic [1:0]              kind;
  logic [swsd_pkg::VW-1:0] value;

  logic [swsd_pkg::CW-1:0] fill;
  logic [swsd_pkg::CW-1:0] fill_dec;
  logic [swsd_pkg::AW-1:0] top_idx;

  // Minimum search. Each search looks for the smallest (value, index) key
  // above the key emitted last, so equal values come out side by side.
  logic [swsd_pkg::AW-1:0]    scan_idx;
  logic                       cmp_vld;
  logic [swsd_pkg::AW-1:0]    cmp_idx;
  logic                       prev_vld;
  logic [swsd_pkg::VW-1:0]    prev_val;
  logic [swsd_pkg::AW-1:0]    prev_idx;
  logic                       above_prev;
  logic                       best_vld;
  logic [swsd_pkg::VW-1:0]    best_val;
  logic [swsd_pkg::AW-1:0]    best_idx;
  logic [swsd_pkg::CW-1:0]    cursor;
  logic [swsd_pkg::CW-1:0]    cursor_inc;
  logic                       sort_last;
  logic                       take_new;
  logic                       out_load;

  assign fill_dec   = fill - swsd_pkg::CW'(1);
  assign top_idx    = fill_dec[swsd_pkg::AW-1:0];
  assign cursor_inc = cursor + swsd_pkg::CW'(1);
  assign sort_last  = (cursor_inc == fill);
  assign rd_addr    = cmd.scan_rd ? scan_idx : top_idx;
  assign above_prev = !prev_vld || ({rd_data, cmp_idx} > {prev_val, prev_idx});
  assign take_new   = cmp_vld && above_prev && (!best_vld || rd_data < best_val);
  assign out_load   = cmd.emit_top || cmd.emit_sort || cmd.emit_code;

  always_comb begin
    sts.kind      = kind;
    sts.full      = (fill == swsd_pkg::CW'(swsd_pkg::DEPTH));
    sts.empty     = (fill == '0);
    sts.scan_last = ({1'b0, scan_idx} == fill_dec);
    sts.sort_last = sort_last;
    sts.out_free  = !out_valid || out_ready;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind  <= in_kind;
      value <= in_value;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[fill[swsd_pkg::AW-1:0]] <= value;
    end
    if (cmd.rd_top || cmd.scan_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Fill count and drain cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      cursor <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + swsd_pkg::CW'(1);
      end else if (cmd.pop) begin
        fill <= fill_dec;
      end
      if (cmd.drain_init) begin
        cursor <= '0;
      end else if (cmd.emit_sort) begin
        if (sort_last) begin
          cursor <= '0;
          fill   <= '0;
        end else begin
          cursor <= cursor_inc;
        end
      end
    end
  end

  // Search scan: address counter, compare stage and last emitted key.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld  <= 1'b0;
      best_vld <= 1'b0;
      prev_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
      if (cmd.scan_init) begin
        best_vld <= 1'b0;
      end else if (take_new) begin
        best_vld <= 1'b1;
      end
      if (cmd.drain_init) begin
        prev_vld <= 1'b0;
      end else if (cmd.emit_sort) begin
        prev_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + swsd_pkg::AW'(1);
    end
    if (take_new) begin
      best_val <= rd_data;
      best_idx <= cmp_idx;
    end
    if (cmd.emit_sort) begin
      prev_val <= best_val;
      prev_idx <= best_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_top) begin
      out_value  <= rd_data;
      out_status <= swsd_pkg::ST_DATA;
      out_last   <= 1'b1;
    end else if (cmd.emit_sort) begin
      out_value  <= best_val;
      out_status <= swsd_pkg::ST_DATA;
      out_last   <= sort_last;
    end else if (cmd.emit_code) begin
      out_value  <= '0;
      out_status <= cmd.code;
      out_last   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/swsd_chk.sv
`default_nettype none

module swsd_chk (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    item_ready,
  input wire logic                    res_valid,
  input wire logic                    res_ready,
  input wire logic [swsd_pkg::VW-1:0] res_value,
  input wire logic [1:0]              res_status,
  input wire logic                    res_last
);

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_value) && $stable(res_status) && $stable(res_last))
    else $error("result payload changed while stalled");

  // Only defined status codes appear, and non-data results carry zero and are marked last.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == swsd_pkg::ST_DATA) || (res_status == swsd_pkg::ST_EMPTY) ||
                  (res_status == swsd_pkg::ST_OVER))
    else $error("undefined status code");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != swsd_pkg::ST_DATA) |-> (res_value == '0) && res_last)
    else $error("status-only result with data or without last");

  // While a drain is still producing, no new request is taken.
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !item_ready)
    else $error("request taken in the middle of a drain");

endmodule

bind stack_with_sorted_drain swsd_chk u_swsd_chk (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_value  (result.value_res),
  .res_status (result.status),
  .res_last   (result.last)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [swsd_pkg::VW-1:0] VAL_MAX = 30'd1000000000;
  localparam int CYCLE_CAP  = 6000000;
  localparam int TAIL_WAIT  = 24;
  localparam int RESET_LEN  = 12;

  // One answer of the stack, as it appears on the result channel.
  typedef struct packed {
    logic [swsd_pkg::VW-1:0] value_res;
    logic [1:0]              status;
    logic                    last;
  } answer_t;

  logic clk;
  logic rst;

  swsd_in_if  item_if ();
  swsd_out_if result_if ();

  stack_with_sorted_drain dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  // Shadow copy of the stack and the answers it still owes.
  logic [swsd_pkg::VW-1:0] stack_mem [swsd_pkg::DEPTH];
  int                      stack_fill = 0;
  answer_t                 pending_answers [$];

  int fail_count = 0;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Drive every input to a known value before the first edge.
  initial begin
    rst              = 1'b1;
    item_if.valid    = 1'b0;
    item_if.kind     = swsd_pkg::KIND_PUSH;
    item_if.value    = '0;
    result_if.ready  = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void expect_answer(logic [swsd_pkg::VW-1:0] v, logic [1:0] st, logic lst);
    answer_t a;
    a.value_res = v;
    a.status    = st;
    a.last      = lst;
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  // Work out the answers one accepted request causes and update the shadow stack.
  function automatic void predict_answers(logic [1:0] k, logic [swsd_pkg::VW-1:0] v);
    logic [swsd_pkg::VW-1:0] sorted [swsd_pkg::DEPTH];
    logic [swsd_pkg::VW-1:0] x;
    int                      j;
    case (k)
      swsd_pkg::KIND_PUSH: begin
        if (stack_fill >= swsd_pkg::DEPTH) begin
          expect_answer('0, swsd_pkg::ST_OVER, 1'b1);
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end
      swsd_pkg::KIND_POP: begin
        if (stack_fill == 0) begin
          expect_answer('0, swsd_pkg::ST_EMPTY, 1'b1);
        end else begin
          stack_fill--;
        end
      end
      swsd_pkg::KIND_PEEK: begin
        if (stack_fill == 0) begin
          expect_answer('0, swsd_pkg::ST_EMPTY, 1'b1);
        end else begin
          expect_answer(stack_mem[stack_fill - 1], swsd_pkg::ST_DATA, 1'b1);
        end
      end
      default: begin
        if (stack_fill == 0) begin
          expect_answer('0, swsd_pkg::ST_EMPTY, 1'b1);
        end else begin
          // Insertion sort keeps equal values next to each other.
          for (int i = 0; i < stack_fill; i++) begin
            x = stack_mem[i];
            j = i;
            while (j > 0 && sorted[j - 1] > x) begin
              sorted[j] = sorted[j - 1];
              j--;
            end
            sorted[j] = x;
          end
          for (int i = 0; i < stack_fill; i++) begin
            expect_answer(sorted[i], swsd_pkg::ST_DATA, i == stack_fill - 1);
          end
          stack_fill = 0;
        end
      end
    endcase
  endfunction

  // Send one request; the sender works in bursts with idle gaps in between.
  task automatic issue_request(input logic [1:0] k, input logic [swsd_pkg::VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      item_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
    end
    item_if.valid <= 1'b1;
    item_if.kind  <= k;
    item_if.value <= v;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
    predict_answers(k, v);
    burst_left--;
  endtask

  function automatic logic [swsd_pkg::VW-1:0] pick_value();
    logic [swsd_pkg::VW-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = swsd_pkg::VW'($urandom_range(0, VAL_MAX));
      1:       v = swsd_pkg::VW'($urandom_range(0, 7));
      2:       v = $urandom_range(0, 1) ? VAL_MAX : '0;
      default: v = 30'd1 << $urandom_range(0, swsd_pkg::VW - 1);
    endcase
    return v;
  endfunction

  // Pop, peek and drain on an empty stack.
  task automatic test_empty_stack();
    issue_request(swsd_pkg::KIND_POP, VAL_MAX);
    issue_request(swsd_pkg::KIND_PEEK, '0);
    issue_request(swsd_pkg::KIND_DRAIN, 30'h2AAAAAAA);
  endtask

  // Extreme values, duplicates, peek after pop and a drain of a few entries.
  task automatic test_field_extremes();
    issue_request(swsd_pkg::KIND_PUSH, '0);
    issue_request(swsd_pkg::KIND_PUSH, VAL_MAX);
    issue_request(swsd_pkg::KIND_PEEK, '0);
    issue_request(swsd_pkg::KIND_PUSH, 30'd536870912);
    issue_request(swsd_pkg::KIND_PUSH, VAL_MAX);
    issue_request(swsd_pkg::KIND_PUSH, 30'd1);
    issue_request(swsd_pkg::KIND_PUSH, '0);
    issue_request(swsd_pkg::KIND_PEEK, VAL_MAX);
    issue_request(swsd_pkg::KIND_POP, '0);
    issue_request(swsd_pkg::KIND_PEEK, '0);
    issue_request(swsd_pkg::KIND_PUSH, 30'd15555555);
    issue_request(swsd_pkg::KIND_DRAIN, '0);
    issue_request(swsd_pkg::KIND_PUSH, 30'd7);
    issue_request(swsd_pkg::KIND_POP, '0);
    issue_request(swsd_pkg::KIND_POP, '0);
    issue_request(swsd_pkg::KIND_PEEK, '0);
  endtask

  // Fill the stack to the brim, overflow it, then drain all of it.
  task automatic test_full_stack();
    while (stack_fill < swsd_pkg::DEPTH) begin
      issue_request(swsd_pkg::KIND_PUSH, pick_value());
    end
    issue_request(swsd_pkg::KIND_PUSH, VAL_MAX);
    issue_request(swsd_pkg::KIND_PUSH, '0);
    issue_request(swsd_pkg::KIND_PEEK, '0);
    issue_request(swsd_pkg::KIND_POP, '0);
    issue_request(swsd_pkg::KIND_PEEK, '0);
    issue_request(swsd_pkg::KIND_PUSH, pick_value());
    issue_request(swsd_pkg::KIND_PUSH, pick_value());
    issue_request(swsd_pkg::KIND_DRAIN, '0);
  endtask

  // Random mix of requests in phases that grow, churn or empty the stack.
  task automatic test_random_mix(input int count);
    int          profile;
    int          r;
    logic [1:0]  k;
    profile = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        profile = $urandom_range(0, 2);
      end
      r = $urandom_range(0, 99);
      case (profile)
        0: k = (r < 40) ? swsd_pkg::KIND_PUSH : (r < 60) ? swsd_pkg::KIND_POP :
               (r < 85) ? swsd_pkg::KIND_PEEK : swsd_pkg::KIND_DRAIN;
        1: k = (r < 70) ? swsd_pkg::KIND_PUSH : (r < 80) ? swsd_pkg::KIND_POP :
               (r < 95) ? swsd_pkg::KIND_PEEK : swsd_pkg::KIND_DRAIN;
        default: k = (r < 20) ? swsd_pkg::KIND_PUSH : (r < 60) ? swsd_pkg::KIND_POP :
                     (r < 80) ? swsd_pkg::KIND_PEEK : swsd_pkg::KIND_DRAIN;
      endcase
      issue_request(k, pick_value());
    end
  endtask

  // Receiver stall pattern: the mode is redrawn whenever its hold counter runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       result_if.ready <= 1'b1;
      1:       result_if.ready <= 1'($urandom_range(0, 1));
      2:       result_if.ready <= (cycle_cnt % 4 == 0);
      default: result_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Compare each accepted answer with the oldest one owed.
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_answers.size() == 0) begin
        note_failure($sformatf("unexpected answer: value %0d status %0d last %0d",
                               result_if.value_res, result_if.status, result_if.last));
      end else begin
        want = pending_answers.pop_front();
        if (result_if.value_res !== want.value_res || result_if.status !== want.status ||
            result_if.last !== want.last) begin
          note_failure($sformatf(
            "answer mismatch: expected value %0d status %0d last %0d, got %0d %0d %0d",
            want.value_res, want.status, want.last,
            result_if.value_res, result_if.status, result_if.last));
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stack();
    test_field_extremes();
    test_full_stack();
    test_random_mix(180);
    item_if.valid <= 1'b0;

    // Let every owed answer arrive, then watch for stray ones.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
